@@ rtl/swlc_pkg.sv @@
// ----------------------------------------------------------------------------
// swlc_pkg
// Shared types, codes and defaults of the write-back lru word cache.
// ----------------------------------------------------------------------------
package swlc_pkg;

    // default sizes
    localparam int DEF_TOTAL_BLOCKS    = 256;
    localparam int DEF_MAX_BLOCK_WORDS = 256;
    localparam int DEF_MEMORY_WORDS    = 65536;

    // request commands
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_STORE   = 2'd1;
    localparam logic [1:0] CMD_PRELOAD = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_BLOCK_WORDS_LOG2 = 2'd0;
    localparam logic [1:0] CFG_SETS_LOG2        = 2'd1;
    localparam logic [1:0] CFG_WAYS             = 2'd2;

    // transfer record actions
    typedef enum logic [2:0] {
        ACT_TO_CPU    = 3'd0,
        ACT_FROM_CPU  = 3'd1,
        ACT_FILL      = 3'd2,
        ACT_WRITEBACK = 3'd3,
        ACT_EVICT     = 3'd4
    } action_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        address;
        logic signed [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [15:0]        first_address;
        logic [15:0]        last_address;
        logic signed [31:0] read_data;
        logic               last_record;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_WB_REC,
        ST_WB_COPY,
        ST_EVICT_REC,
        ST_FILL_REC,
        ST_FILL_COPY,
        ST_PROC_READ,
        ST_PROC_REC
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic    take;
        logic    clr_step;
        logic    scan;
        logic    cnt_clr;
        logic    wb_copy;
        logic    fill_copy;
        logic    proc_read;
        logic    emit;
        action_t action;
    } ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic copy_last;
        logic hit_found;
        logic victim_valid;
        logic victim_dirty;
        logic out_free;
        logic is_load;
    } status_t;

endpackage

@@ rtl/swlc_ctrl.sv @@
// ----------------------------------------------------------------------------
// swlc_ctrl
// Sequencer: memory clear, way scan, write-back, fill and processor transfer.
// ----------------------------------------------------------------------------
module swlc_ctrl
    import swlc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_command,
    input  status_t    status,
    output ctl_t       ctl,
    output logic       in_stall
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && (in_command == CMD_LOAD || in_command == CMD_STORE))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.hit_found)
                begin
                    state_next = status.is_load ? ST_PROC_READ : ST_PROC_REC;
                end
                else if (status.victim_valid && status.victim_dirty)
                begin
                    state_next = ST_WB_REC;
                end
                else if (status.victim_valid)
                begin
                    state_next = ST_EVICT_REC;
                end
                else
                begin
                    state_next = ST_FILL_REC;
                end
            end
            ST_WB_REC:
            begin
                if (status.out_free)
                begin
                    state_next = ST_WB_COPY;
                end
            end
            ST_WB_COPY:
            begin
                if (status.copy_last)
                begin
                    state_next = ST_FILL_REC;
                end
            end
            ST_EVICT_REC:
            begin
                if (status.out_free)
                begin
                    state_next = ST_FILL_REC;
                end
            end
            ST_FILL_REC:
            begin
                if (status.out_free)
                begin
                    state_next = ST_FILL_COPY;
                end
            end
            ST_FILL_COPY:
            begin
                if (status.copy_last)
                begin
                    state_next = status.is_load ? ST_PROC_READ : ST_PROC_REC;
                end
            end
            ST_PROC_READ:
            begin
                state_next = ST_PROC_REC;
            end
            ST_PROC_REC:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        ctl        = '0;
        ctl.action = ACT_TO_CPU;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                ctl.take = in_valid;
            end
            ST_SCAN:
            begin
                ctl.scan = 1'b1;
            end
            ST_DECIDE:
            begin
                ctl.cnt_clr = 1'b1;
            end
            ST_WB_REC:
            begin
                ctl.cnt_clr = 1'b1;
                ctl.emit    = 1'b1;
                ctl.action  = ACT_WRITEBACK;
            end
            ST_WB_COPY:
            begin
                ctl.wb_copy = 1'b1;
            end
            ST_EVICT_REC:
            begin
                ctl.emit   = 1'b1;
                ctl.action = ACT_EVICT;
            end
            ST_FILL_REC:
            begin
                ctl.cnt_clr = 1'b1;
                ctl.emit    = 1'b1;
                ctl.action  = ACT_FILL;
            end
            ST_FILL_COPY:
            begin
                ctl.fill_copy = 1'b1;
            end
            ST_PROC_READ:
            begin
                ctl.proc_read = 1'b1;
            end
            ST_PROC_REC:
            begin
                ctl.emit   = 1'b1;
                ctl.action = status.is_load ? ACT_TO_CPU : ACT_FROM_CPU;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

@@ rtl/swlc_dp.sv @@
// ----------------------------------------------------------------------------
// swlc_dp
// Datapath: geometry, tag scan, block data and backing memories, output stage.
// ----------------------------------------------------------------------------
module swlc_dp
    import swlc_pkg::*;
#(
    parameter int TOTAL_BLOCKS    = DEF_TOTAL_BLOCKS,
    parameter int MAX_BLOCK_WORDS = DEF_MAX_BLOCK_WORDS,
    parameter int MEMORY_WORDS    = DEF_MEMORY_WORDS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctl_t       ctl,
    input  req_t       in_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,
    output status_t    status,
    output logic       out_valid,
    input  logic       out_stall,
    output rsp_t       out_data
);

    localparam int BLK_AW   = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
    localparam int BD_DEPTH = TOTAL_BLOCKS * MAX_BLOCK_WORDS;
    localparam int BD_AW    = (BD_DEPTH > 1) ? $clog2(BD_DEPTH) : 1;
    localparam int MEM_AW   = $clog2(MEMORY_WORDS);
    localparam int MBW_LOG2 = $clog2(MAX_BLOCK_WORDS + 1) - 1;
    localparam int TB_LOG2  = $clog2(TOTAL_BLOCKS + 1) - 1;

    // configuration registers
    logic [3:0] cfg_bwl_reg;
    logic [3:0] cfg_sl_reg;
    logic [8:0] cfg_ways_reg;

    // request and geometry latched at accept
    req_t              req_reg;
    logic [8:0]        bw_reg;
    logic [8:0]        nw_reg;
    logic [BLK_AW-1:0] start_reg;
    logic [8:0]        off_reg;
    logic [15:0]       fill_reg;

    // scan and copy state
    logic [8:0]        cnt_reg;
    logic              pend_reg;
    logic [BLK_AW-1:0] rd_blk_reg;
    logic              hit_found_reg;
    logic [BLK_AW-1:0] hit_idx_reg;
    logic [BLK_AW-1:0] victim_idx_reg;
    logic [15:0]       victim_base_reg;
    logic [16:0]       best_reg;
    logic              best_valid_reg;
    logic [MEM_AW-1:0] clr_cnt_reg;

    // per block flags
    logic [TOTAL_BLOCKS-1:0] valid_reg;
    logic [TOTAL_BLOCKS-1:0] dirty_reg;

    // memories and their read registers
    logic [31:0] tag_mem [TOTAL_BLOCKS];
    logic [31:0] bd_mem  [BD_DEPTH];
    logic [31:0] bk_mem  [MEMORY_WORDS];
    logic [31:0] tag_rdata_reg;
    logic [31:0] bd_rdata_reg;
    logic [31:0] bk_rdata_reg;

    // output stage
    logic out_valid_reg;
    rsp_t out_reg;

    // combinational helpers
    logic [3:0]        geo_bl;
    logic [3:0]        geo_sl;
    logic [10:0]       geo_maxw;
    logic [8:0]        geo_maxw_cap;
    logic [8:0]        geo_nw;
    logic [8:0]        geo_bw;
    logic [15:0]       geo_set16;
    logic [15:0]       geo_mask;
    logic [7:0]        geo_set;
    logic [16:0]       geo_prod;
    logic [10:0]       blk_sum;
    logic [BLK_AW-1:0] scan_blk;
    logic [15:0]       tag_base;
    logic [15:0]       tag_age;
    logic [15:0]       age_new;
    logic              way_valid;
    logic              way_hit;
    logic              take_best;
    logic              scan_issue;
    logic              copy_issue;
    logic [8:0]        cnt_m1;
    logic              out_free;
    logic              emit_do;
    logic              store_do;
    logic              fill_done;
    logic [15:0]       wb_addr;
    logic [15:0]       fill_addr;
    logic [15:0]       bw_m1;
    rsp_t              rec;

    function automatic logic [BD_AW-1:0] bd_index(input logic [BLK_AW-1:0] blk,
                                                   input logic [8:0] word);
        bd_index = BD_AW'(blk) * BD_AW'(MAX_BLOCK_WORDS) + BD_AW'(word);
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_bwl_reg  <= 4'd0;
            cfg_sl_reg   <= 4'd0;
            cfg_ways_reg <= 9'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLOCK_WORDS_LOG2: cfg_bwl_reg  <= cfg_data[3:0];
                CFG_SETS_LOG2:        cfg_sl_reg   <= cfg_data[3:0];
                CFG_WAYS:             cfg_ways_reg <= cfg_data;
                default:              cfg_ways_reg <= cfg_ways_reg;
            endcase
        end
    end

    // effective geometry and set start for the incoming request
    always_comb
    begin
        geo_bl = (cfg_bwl_reg > 4'd8) ? 4'd8 : cfg_bwl_reg;
        if (geo_bl > 4'(MBW_LOG2))
        begin
            geo_bl = 4'(MBW_LOG2);
        end
        geo_sl = (cfg_sl_reg > 4'd8) ? 4'd8 : cfg_sl_reg;
        if (geo_sl > 4'(TB_LOG2))
        begin
            geo_sl = 4'(TB_LOG2);
        end
        geo_maxw     = 11'(TOTAL_BLOCKS) >> geo_sl;
        geo_maxw_cap = (geo_maxw > 11'd256) ? 9'd256 : geo_maxw[8:0];
        geo_nw       = (cfg_ways_reg == 9'd0) ? 9'd1 : cfg_ways_reg;
        if (geo_nw > 9'd256)
        begin
            geo_nw = 9'd256;
        end
        if (geo_nw > geo_maxw_cap)
        begin
            geo_nw = geo_maxw_cap;
        end
        geo_bw    = 9'd1 << geo_bl;
        geo_set16 = in_data.address >> geo_bl;
        geo_mask  = (16'd1 << geo_sl) - 16'd1;
        geo_set   = 8'(geo_set16 & geo_mask);
        geo_prod  = 17'(geo_set) * 17'(geo_nw);
    end

    // scan way evaluation
    always_comb
    begin
        blk_sum    = 11'(start_reg) + 11'(cnt_reg);
        scan_blk   = blk_sum[BLK_AW-1:0];
        scan_issue = ctl.scan && (cnt_reg < nw_reg);
        tag_base   = tag_rdata_reg[31:16];
        tag_age    = tag_rdata_reg[15:0];
        way_valid  = valid_reg[rd_blk_reg];
        way_hit    = (req_reg.address >= tag_base) &&
                     ({1'b0, req_reg.address} < ({1'b0, tag_base} + 17'(bw_reg)));
        take_best  = !best_valid_reg || ({1'b0, tag_age} > best_reg);
        if (way_hit)
        begin
            age_new = 16'd0;
        end
        else if (tag_age == 16'hFFFF)
        begin
            age_new = tag_age;
        end
        else
        begin
            age_new = tag_age + 16'd1;
        end
    end

    // copy and output helpers
    assign cnt_m1     = cnt_reg - 9'd1;
    assign copy_issue = cnt_reg < bw_reg;
    assign fill_done  = ctl.fill_copy && (cnt_reg == bw_reg);
    assign wb_addr    = victim_base_reg + 16'(cnt_m1);
    assign fill_addr  = fill_reg + 16'(cnt_reg);
    assign bw_m1      = 16'(bw_reg) - 16'd1;
    assign out_free   = !out_valid_reg || !out_stall;
    assign emit_do    = ctl.emit && out_free;
    assign store_do   = emit_do && (ctl.action == ACT_FROM_CPU);

    // counters and scan results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= 9'd0;
            pend_reg       <= 1'b0;
            hit_found_reg  <= 1'b0;
            best_valid_reg <= 1'b0;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            if (ctl.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + MEM_AW'(1);
            end
            if (ctl.take)
            begin
                cnt_reg        <= 9'd0;
                pend_reg       <= 1'b0;
                hit_found_reg  <= 1'b0;
                best_valid_reg <= 1'b0;
            end
            else if (ctl.scan)
            begin
                pend_reg <= scan_issue;
                if (scan_issue)
                begin
                    cnt_reg <= cnt_reg + 9'd1;
                end
                if (pend_reg)
                begin
                    if (!way_valid)
                    begin
                        best_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        if (take_best)
                        begin
                            best_valid_reg <= 1'b1;
                        end
                        if (way_hit)
                        begin
                            hit_found_reg <= 1'b1;
                        end
                    end
                end
            end
            else if (ctl.cnt_clr)
            begin
                cnt_reg <= 9'd0;
            end
            else if (ctl.wb_copy || ctl.fill_copy)
            begin
                cnt_reg <= cnt_reg + 9'd1;
            end
        end
    end

    // payload registers of request, victim and hit
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            req_reg   <= in_data;
            bw_reg    <= geo_bw;
            nw_reg    <= geo_nw;
            start_reg <= geo_prod[BLK_AW-1:0];
            off_reg   <= in_data.address[8:0] & (geo_bw - 9'd1);
            fill_reg  <= in_data.address & ~(16'(geo_bw) - 16'd1);
        end
        if (scan_issue)
        begin
            rd_blk_reg <= scan_blk;
        end
        if (ctl.scan && pend_reg)
        begin
            if (!way_valid)
            begin
                victim_idx_reg <= rd_blk_reg;
                best_reg       <= 17'h10000;
            end
            else
            begin
                if (take_best)
                begin
                    victim_idx_reg  <= rd_blk_reg;
                    victim_base_reg <= tag_base;
                    best_reg        <= {1'b0, tag_age};
                end
                if (way_hit)
                begin
                    hit_idx_reg <= rd_blk_reg;
                end
            end
        end
        if (fill_done)
        begin
            hit_idx_reg <= victim_idx_reg;
        end
    end

    // valid and dirty flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
        end
        else if (fill_done)
        begin
            valid_reg[victim_idx_reg] <= 1'b1;
            dirty_reg[victim_idx_reg] <= 1'b0;
        end
        else if (store_do)
        begin
            dirty_reg[hit_idx_reg] <= 1'b1;
        end
    end

    // tag memory: base and age per block
    always_ff @(posedge clk)
    begin
        if (fill_done)
        begin
            tag_mem[victim_idx_reg] <= {fill_reg, 16'd0};
        end
        else if (ctl.scan && pend_reg && way_valid)
        begin
            tag_mem[rd_blk_reg] <= {tag_base, age_new};
        end
        if (scan_issue)
        begin
            tag_rdata_reg <= tag_mem[scan_blk];
        end
    end

    // block data memory
    always_ff @(posedge clk)
    begin
        if (ctl.fill_copy && (cnt_reg != 9'd0))
        begin
            bd_mem[bd_index(victim_idx_reg, cnt_m1)] <= bk_rdata_reg;
        end
        else if (store_do)
        begin
            bd_mem[bd_index(hit_idx_reg, off_reg)] <= req_reg.write_data;
        end
        if (ctl.wb_copy && copy_issue)
        begin
            bd_rdata_reg <= bd_mem[bd_index(victim_idx_reg, cnt_reg)];
        end
        else if (ctl.proc_read)
        begin
            bd_rdata_reg <= bd_mem[bd_index(hit_idx_reg, off_reg)];
        end
    end

    // backing memory
    always_ff @(posedge clk)
    begin
        if (ctl.clr_step)
        begin
            bk_mem[clr_cnt_reg] <= 32'd0;
        end
        else if (ctl.take && (in_data.command == CMD_PRELOAD))
        begin
            bk_mem[in_data.address[MEM_AW-1:0]] <= in_data.write_data;
        end
        else if (ctl.wb_copy && (cnt_reg != 9'd0))
        begin
            bk_mem[wb_addr[MEM_AW-1:0]] <= bd_rdata_reg;
        end
        if (ctl.fill_copy && copy_issue)
        begin
            bk_rdata_reg <= bk_mem[fill_addr[MEM_AW-1:0]];
        end
    end

    // record formation
    always_comb
    begin
        rec             = '0;
        rec.action      = ctl.action;
        rec.first_address = req_reg.address;
        rec.last_address  = req_reg.address;
        case (ctl.action)
            ACT_WRITEBACK, ACT_EVICT:
            begin
                rec.first_address = victim_base_reg;
                rec.last_address  = victim_base_reg + bw_m1;
            end
            ACT_FILL:
            begin
                rec.first_address = fill_reg;
                rec.last_address  = fill_reg + bw_m1;
            end
            ACT_TO_CPU:
            begin
                rec.read_data   = bd_rdata_reg;
                rec.last_record = 1'b1;
            end
            default:
            begin
                rec.last_record = 1'b1;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_do)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_do)
        begin
            out_reg <= rec;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // status to the controller
    assign status.clr_last     = clr_cnt_reg == MEM_AW'(MEMORY_WORDS - 1);
    assign status.scan_last    = cnt_reg == nw_reg;
    assign status.copy_last    = cnt_reg == bw_reg;
    assign status.hit_found    = hit_found_reg;
    assign status.victim_valid = valid_reg[victim_idx_reg];
    assign status.victim_dirty = dirty_reg[victim_idx_reg];
    assign status.out_free     = out_free;
    assign status.is_load      = req_reg.command == CMD_LOAD;

endmodule

@@ rtl/set_assoc_writeback_lru_cache.sv @@
// ----------------------------------------------------------------------------
// set_assoc_writeback_lru_cache
// Set-associative write-back, write-allocate word cache with lru ages.
// ----------------------------------------------------------------------------
// Requests (load, store, preload) enter on in_valid/in_stall; each load or
// store gives one to three transfer records on out_valid/out_stall, the final
// one flagged by last_record. Preload writes the backing memory only.
// Geometry is written through cfg_we/cfg_index/cfg_data while idle: the user
// must keep to this, as the block itself does not enforce it. A hit is bounded
// by the way scan, which reads one tag entry per cycle from the tag memory.
// A miss adds a fill and, for a dirty victim, a write-back of the block, each
// word moving through one memory port; a clean victim is dropped with an
// evict record. Preload and the unused command give no record and leave the
// block idle. After reset the backing memory, MEMORY_WORDS words (65536 by
// default), is cleared one word per cycle; in_stall stays high meanwhile.
// A stalled record holds the output register; the block waits for it before
// producing the next record, and takes the next request once the last
// record of a transaction is registered.
// ----------------------------------------------------------------------------
module set_assoc_writeback_lru_cache
    import swlc_pkg::*;
#(
    parameter int TOTAL_BLOCKS    = DEF_TOTAL_BLOCKS,
    parameter int MAX_BLOCK_WORDS = DEF_MAX_BLOCK_WORDS,
    parameter int MEMORY_WORDS    = DEF_MEMORY_WORDS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  req_t       in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output rsp_t       out_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data
);

    ctl_t    ctl;
    status_t status;

    // sequencer
    swlc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_data.command),
        .status     (status),
        .ctl        (ctl),
        .in_stall   (in_stall)
    );

    // datapath and memories
    swlc_dp #(
        .TOTAL_BLOCKS    (TOTAL_BLOCKS),
        .MAX_BLOCK_WORDS (MAX_BLOCK_WORDS),
        .MEMORY_WORDS    (MEMORY_WORDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
